// ===== sv/ppu_pkg.sv =====
// shared types and codes for the particle pool update block
`default_nettype none
package ppu_pkg;

    localparam logic OP_SPAWN = 1'b0;
    localparam logic OP_TICK  = 1'b1;

    localparam logic [1:0] KIND_SPAWN  = 2'd0;
    localparam logic [1:0] KIND_RECORD = 2'd1;
    localparam logic [1:0] KIND_EMPTY  = 2'd2;

    localparam int QUOT_W = 17;

    typedef struct packed {
        logic [31:0] pos_x;
        logic [31:0] pos_y;
        logic [31:0] pos_z;
        logic [31:0] vel_x;
        logic [31:0] vel_y;
        logic [31:0] vel_z;
        logic [31:0] size;
        logic [30:0] life_left;
        logic [30:0] life_total;
        logic [31:0] grav;
        logic [31:0] start_rgba;
        logic [31:0] end_rgba;
    } entry_t;

    typedef struct packed {
        logic              start;
        logic [30:0]       num;
        logic [30:0]       den;
    } div_req_t;

    typedef struct packed {
        logic              done;
        logic [QUOT_W-1:0] quot;
    } div_rsp_t;

endpackage
`default_nettype wire

// ===== sv/ppu_store.sv =====
// particle state memory, one entry per particle, registered read
`default_nettype none
module ppu_store #(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  wire logic            clk,
    input  wire logic            wr_en,
    input  wire logic [AW-1:0]   wr_addr,
    input  wire ppu_pkg::entry_t wr_data,
    input  wire logic            rd_en,
    input  wire logic [AW-1:0]   rd_addr,
    output ppu_pkg::entry_t      rd_data
);

    ppu_pkg::entry_t mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule
`default_nettype wire

// ===== sv/ppu_divider.sv =====
// restoring divider for the life fraction, one quotient bit a cycle
`default_nettype none
module ppu_divider (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire ppu_pkg::div_req_t req,
    output ppu_pkg::div_rsp_t      rsp
);

    logic                        busy_reg;
    logic [4:0]                  cnt_reg;
    logic [31:0]                 rem_reg;
    logic [30:0]                 den_reg;
    logic [ppu_pkg::QUOT_W-1:0]  quot_reg;
    logic                        done_reg;

    logic        bit_q;
    logic [31:0] rem_sub;

    always_comb
    begin
        bit_q   = rem_reg >= {1'b0, den_reg};
        rem_sub = bit_q ? (rem_reg - {1'b0, den_reg}) : rem_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 5'd1;
                if (cnt_reg == 5'd1)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
            else if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= 5'(ppu_pkg::QUOT_W);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (busy_reg)
        begin
            quot_reg <= {quot_reg[ppu_pkg::QUOT_W-2:0], bit_q};
            rem_reg  <= {rem_sub[30:0], 1'b0};
        end
        else if (req.start)
        begin
            rem_reg  <= {1'b0, req.num};
            den_reg  <= req.den;
            quot_reg <= '0;
        end
    end

    assign rsp.done = done_reg;
    assign rsp.quot = quot_reg;

endmodule
`default_nettype wire

// ===== sv/particle_pool_update.sv =====
// particle pool update top level: sequencer, update datapath, blend and ports
// usage:
//   items arrive on the s_ stream (tuser = op, tdata = spawn/tick fields) and results
//   leave on the m_ stream (tuser = kind, tlast = last of the item's results)
//   registers gravity_accel (byte 0) and pool_limit (byte 4) sit on the apb port
// flow:
//   a spawn loads its reply into the output register once that is free, then the input is free again
//   a tick is two passes over the alive particles held in one memory:
//   the update pass reads and life-checks each particle, skips a dropped one and runs a
//   survivor through one shared 32x32 multiplier, used four times, before writing it back
//   compacted; the emit pass reads each survivor, waits for the 17-step fraction divider,
//   blends its colour and loads its record once the output register is free
//   a tick that leaves nothing gives one empty record after its update pass
// behaviour:
//   one item is worked on at a time; a new item is taken while the last
//   result still waits in the output register
//   if the receiver stalls, the sequencer holds before loading the next result
//   reset empties the pool, gravity_accel goes to 0 and pool_limit to 64;
//   no clearing pass, entries are only read below the alive count
`default_nettype none
module particle_pool_update #(
    parameter int POOL_DEPTH = 64
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    // apb configuration port
    input  wire logic          psel,
    input  wire logic          penable,
    input  wire logic          pwrite,
    input  wire logic [2:0]    paddr,
    input  wire logic [31:0]   pwdata,
    output logic      [31:0]   prdata,
    output logic               pready,
    // input stream
    input  wire logic          s_tvalid,
    output logic               s_tready,
    // pos_x, pos_y, pos_z, vel_x, vel_y, vel_z, point_size, lifetime(31),
    // start_rgba, end_rgba, step_time(31), 2 bits pad
    input  wire logic [351:0]  s_tdata,
    // op
    input  wire logic          s_tuser,
    // output stream
    output logic               m_tvalid,
    input  wire logic          m_tready,
    // accepted, out_x, out_y, out_z, out_size, out_rgba, alive_count(7)
    output logic [167:0]       m_tdata,
    // kind
    output logic [1:0]         m_tuser,
    output logic               m_tlast
);

    localparam int CW = $clog2(POOL_DEPTH + 1);
    localparam int AW = (POOL_DEPTH > 1) ? $clog2(POOL_DEPTH) : 1;

    localparam logic ADDR_GRAVITY = 1'b0;
    localparam logic ADDR_LIMIT   = 1'b1;

    typedef enum logic [11:0] {
        ST_IDLE    = 12'b000000000001,
        ST_SPAWN   = 12'b000000000010,
        ST_T_RD    = 12'b000000000100,
        ST_T_CHK   = 12'b000000001000,
        ST_T_MUL   = 12'b000000010000,
        ST_EMPTY   = 12'b000000100000,
        ST_P_RD    = 12'b000001000000,
        ST_P_DIV   = 12'b000010000000,
        ST_P_WAIT  = 12'b000100000000,
        ST_P_BLEND = 12'b001000000000,
        ST_P_EMIT  = 12'b010000000000,
        ST_P_NEXT  = 12'b100000000000
    } state_t;

    function automatic logic [31:0] sat32(input logic signed [48:0] v);
        if (v > 49'sd2147483647)
        begin
            return 32'h7fffffff;
        end
        else if (v < -49'sd2147483648)
        begin
            return 32'h80000000;
        end
        return v[31:0];
    endfunction

    function automatic logic [31:0] blend(input logic [31:0] s, input logic [31:0] e,
                                          input logic [16:0] t);
        logic [31:0] res;
        logic [25:0] acc;
        logic [16:0] u;
        u   = 17'd65536 - t;
        res = '0;
        for (int k = 0; k < 4; k++)
        begin
            acc = {18'd0, s[8*k +: 8]} * {9'd0, u} + {18'd0, e[8*k +: 8]} * {9'd0, t}
                  + 26'd32768;
            res[8*k +: 8] = (acc[25:16] > 10'd255) ? 8'hff : acc[23:16];
        end
        return res;
    endfunction

    // configuration
    logic [31:0] gravity_reg;
    logic [6:0]  limit_reg;
    logic        cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;
    assign prdata = (paddr[2] == ADDR_LIMIT) ? {25'd0, limit_reg} : gravity_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gravity_reg <= '0;
            limit_reg   <= 7'd64;
        end
        else if (cfg_wr)
        begin
            if (paddr[2] == ADDR_GRAVITY)
            begin
                gravity_reg <= pwdata;
            end
            else
            begin
                limit_reg <= pwdata[6:0];
            end
        end
    end

    // sequencer state
    state_t        state_reg;
    logic [CW-1:0] live_reg;
    logic [CW-1:0] rd_idx_reg;   // update pass read index, emit pass index
    logic [CW-1:0] wr_idx_reg;   // compaction write index
    logic [2:0]    step_reg;
    logic          ok_reg;

    // captured item
    logic [351:0]  in_reg;
    logic          op_reg;

    // datapath registers
    logic [30:0]        life_reg;
    logic signed [63:0] prod_reg;
    logic [31:0]        vy_reg;
    logic [31:0]        px_reg;
    logic [31:0]        py_reg;
    logic [31:0]        rgba_reg;

    // output register
    logic        out_valid_reg;
    logic [1:0]  out_kind_reg;
    logic        out_acc_reg;
    logic [31:0] out_x_reg;
    logic [31:0] out_y_reg;
    logic [31:0] out_z_reg;
    logic [31:0] out_size_reg;
    logic [31:0] out_rgba_reg;
    logic [6:0]  out_alive_reg;
    logic        out_last_reg;

    logic out_free;
    logic out_load;
    assign out_free = !out_valid_reg || m_tready;
    // a result is loaded into the output register this cycle
    assign out_load = out_free && (state_reg == ST_SPAWN || state_reg == ST_EMPTY ||
                                   state_reg == ST_P_EMIT);

    // input field views
    logic [30:0] step_time;

    ppu_pkg::entry_t spawn_entry;
    always_comb
    begin
        spawn_entry.pos_x      = in_reg[31:0];
        spawn_entry.pos_y      = in_reg[63:32];
        spawn_entry.pos_z      = in_reg[95:64];
        spawn_entry.vel_x      = in_reg[127:96];
        spawn_entry.vel_y      = in_reg[159:128];
        spawn_entry.vel_z      = in_reg[191:160];
        spawn_entry.size       = in_reg[223:192];
        spawn_entry.life_left  = in_reg[254:224];
        spawn_entry.life_total = in_reg[254:224];
        spawn_entry.grav       = gravity_reg;
        spawn_entry.start_rgba = in_reg[286:255];
        spawn_entry.end_rgba   = in_reg[318:287];
    end
    assign step_time = in_reg[349:319];

    // memory
    logic            mem_wr_en;
    logic [AW-1:0]   mem_wr_addr;
    ppu_pkg::entry_t mem_wr_data;
    logic            mem_rd_en;
    logic [AW-1:0]   mem_rd_addr;
    ppu_pkg::entry_t ent;

    ppu_store #(
        .DEPTH (POOL_DEPTH),
        .AW    (AW)
    ) u_store (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (ent)
    );

    // divider for the life fraction
    ppu_pkg::div_req_t div_req;
    ppu_pkg::div_rsp_t div_rsp;

    ppu_divider u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    assign div_req.start = (state_reg == ST_P_DIV);
    assign div_req.num   = ent.life_left;
    assign div_req.den   = ent.life_total;

    // capacity and life test
    logic [6:0]         cap;
    logic signed [32:0] life_diff;
    assign cap       = (limit_reg > 7'(POOL_DEPTH)) ? 7'(POOL_DEPTH) : limit_reg;
    assign life_diff = $signed({2'b00, ent.life_left}) - $signed({2'b00, step_time});

    // shared multiplier: gravity, then vel x, new vel y, vel z times step
    logic signed [31:0] mul_a;
    logic signed [63:0] mul_p;
    always_comb
    begin
        case (step_reg)
            3'd0:    mul_a = $signed(ent.grav);
            3'd1:    mul_a = $signed(ent.vel_x);
            3'd2:    mul_a = $signed(vy_reg);
            default: mul_a = $signed(ent.vel_z);
        endcase
    end
    assign mul_p = mul_a * $signed({1'b0, step_time});

    // accumulate base for the product finished last cycle
    logic signed [31:0] acc_base;
    logic [31:0]        acc_res;
    always_comb
    begin
        case (step_reg)
            3'd1:    acc_base = $signed(ent.vel_y);
            3'd2:    acc_base = $signed(ent.pos_x);
            3'd3:    acc_base = $signed(ent.pos_y);
            default: acc_base = $signed(ent.pos_z);
        endcase
        acc_res = sat32(49'(acc_base) + 49'($signed(prod_reg[63:16])));
    end

    // blend factor
    logic [16:0] t_val;
    always_comb
    begin
        if (ent.life_total == '0)
        begin
            t_val = 17'd65536;
        end
        else if (div_rsp.quot >= 17'd65536)
        begin
            t_val = '0;
        end
        else
        begin
            t_val = 17'd65536 - div_rsp.quot;
        end
    end

    // memory port control
    always_comb
    begin
        mem_wr_en   = 1'b0;
        mem_wr_addr = wr_idx_reg[AW-1:0];
        mem_wr_data = spawn_entry;
        mem_rd_en   = 1'b0;
        mem_rd_addr = rd_idx_reg[AW-1:0];
        if (state_reg == ST_SPAWN && out_free && ok_reg)
        begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = live_reg[AW-1:0];
        end
        else if (state_reg == ST_T_MUL && step_reg == 3'd4)
        begin
            mem_wr_en             = 1'b1;
            mem_wr_data           = ent;
            mem_wr_data.pos_x     = px_reg;
            mem_wr_data.pos_y     = py_reg;
            mem_wr_data.pos_z     = acc_res;
            mem_wr_data.vel_y     = vy_reg;
            mem_wr_data.life_left = life_reg;
        end
        if ((state_reg == ST_T_RD && rd_idx_reg != live_reg) || state_reg == ST_P_RD)
        begin
            mem_rd_en = 1'b1;
        end
    end

    // output valid: set on load, cleared once the transfer is taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            live_reg      <= '0;
            rd_idx_reg    <= '0;
            wr_idx_reg    <= '0;
            step_reg      <= '0;
            ok_reg        <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (s_tvalid)
                    begin
                        rd_idx_reg <= '0;
                        wr_idx_reg <= '0;
                        ok_reg     <= 7'(live_reg) < cap;
                        state_reg  <= (s_tuser == ppu_pkg::OP_TICK) ? ST_T_RD : ST_SPAWN;
                    end
                end
                ST_SPAWN:
                begin
                    if (out_free)
                    begin
                        if (ok_reg)
                        begin
                            live_reg <= live_reg + CW'(1);
                        end
                        state_reg <= ST_IDLE;
                    end
                end
                ST_T_RD:
                begin
                    if (rd_idx_reg == live_reg)
                    begin
                        live_reg   <= wr_idx_reg;
                        rd_idx_reg <= '0;
                        state_reg  <= (wr_idx_reg == '0) ? ST_EMPTY : ST_P_RD;
                    end
                    else
                    begin
                        state_reg <= ST_T_CHK;
                    end
                end
                ST_T_CHK:
                begin
                    step_reg <= '0;
                    if (life_diff <= 33'sd0)
                    begin
                        rd_idx_reg <= rd_idx_reg + CW'(1);
                        state_reg  <= ST_T_RD;
                    end
                    else
                    begin
                        state_reg <= ST_T_MUL;
                    end
                end
                ST_T_MUL:
                begin
                    step_reg <= step_reg + 3'd1;
                    if (step_reg == 3'd4)
                    begin
                        rd_idx_reg <= rd_idx_reg + CW'(1);
                        wr_idx_reg <= wr_idx_reg + CW'(1);
                        state_reg  <= ST_T_RD;
                    end
                end
                ST_EMPTY:
                begin
                    if (out_free)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_P_RD:
                begin
                    state_reg <= ST_P_DIV;
                end
                ST_P_DIV:
                begin
                    state_reg <= ST_P_WAIT;
                end
                ST_P_WAIT:
                begin
                    if (div_rsp.done)
                    begin
                        state_reg <= ST_P_BLEND;
                    end
                end
                ST_P_BLEND:
                begin
                    state_reg <= ST_P_EMIT;
                end
                ST_P_EMIT:
                begin
                    if (out_free)
                    begin
                        state_reg <= ST_P_NEXT;
                    end
                end
                ST_P_NEXT:
                begin
                    rd_idx_reg <= rd_idx_reg + CW'(1);
                    state_reg  <= (rd_idx_reg + CW'(1) == live_reg) ? ST_IDLE : ST_P_RD;
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && s_tvalid)
        begin
            in_reg <= s_tdata;
            op_reg <= s_tuser;
        end
        if (state_reg == ST_T_CHK)
        begin
            life_reg <= life_diff[30:0];
        end
        if (state_reg == ST_T_MUL)
        begin
            prod_reg <= mul_p;
            case (step_reg)
                3'd1:    vy_reg <= acc_res;
                3'd2:    px_reg <= acc_res;
                3'd3:    py_reg <= acc_res;
                default: ;
            endcase
        end
        if (state_reg == ST_P_BLEND)
        begin
            rgba_reg <= blend(ent.start_rgba, ent.end_rgba, t_val);
        end
        if (state_reg == ST_SPAWN && out_free)
        begin
            out_kind_reg  <= ppu_pkg::KIND_SPAWN;
            out_acc_reg   <= ok_reg;
            out_x_reg     <= '0;
            out_y_reg     <= '0;
            out_z_reg     <= '0;
            out_size_reg  <= '0;
            out_rgba_reg  <= '0;
            out_alive_reg <= 7'(live_reg) + {6'd0, ok_reg};
            out_last_reg  <= 1'b1;
        end
        else if (state_reg == ST_EMPTY && out_free)
        begin
            out_kind_reg  <= ppu_pkg::KIND_EMPTY;
            out_acc_reg   <= 1'b0;
            out_x_reg     <= '0;
            out_y_reg     <= '0;
            out_z_reg     <= '0;
            out_size_reg  <= '0;
            out_rgba_reg  <= '0;
            out_alive_reg <= '0;
            out_last_reg  <= 1'b1;
        end
        else if (state_reg == ST_P_EMIT && out_free)
        begin
            out_kind_reg  <= ppu_pkg::KIND_RECORD;
            out_acc_reg   <= 1'b0;
            out_x_reg     <= ent.pos_x;
            out_y_reg     <= ent.pos_y;
            out_z_reg     <= ent.pos_z;
            out_size_reg  <= ent.size;
            out_rgba_reg  <= rgba_reg;
            out_alive_reg <= 7'(live_reg);
            out_last_reg  <= (rd_idx_reg + CW'(1) == live_reg) || (op_reg != ppu_pkg::OP_TICK);
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_kind_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {out_alive_reg, out_rgba_reg, out_size_reg,
                       out_z_reg, out_y_reg, out_x_reg, out_acc_reg};

endmodule
`default_nettype wire

// ===== test/particle_pool_update_tb.sv =====
// testbench for the particle pool update block: spawn and tick streams checked against a predictor
`timescale 1ns / 1ps
`default_nettype none
module particle_pool_update_tb;

    localparam int DEPTH      = 64;
    localparam int CYCLE_CAP  = 1500000;
    localparam int TAIL_WAIT  = 2000;
    localparam logic [2:0] ADDR_GRAVITY = 3'd0;
    localparam logic [2:0] ADDR_LIMIT   = 3'd4;

    // one input item as it travels on the s_ stream
    typedef struct {
        logic        op;
        logic [351:0] data;
    } item_t;

    // one expected result
    typedef struct packed {
        logic [1:0]  kind;
        logic        accepted;
        logic [31:0] x, y, z, size, rgba;
        logic [6:0]  alive;
        logic        last;
    } vertex_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [2:0] paddr = '0;
    logic [31:0] pwdata = '0;
    wire  [31:0] prdata;
    wire  pready;
    logic s_tvalid = 1'b0;
    wire  s_tready;
    logic [351:0] s_tdata = '0;
    logic s_tuser = 1'b0;
    wire  m_tvalid;
    logic m_tready = 1'b0;
    wire  [167:0] m_tdata;
    wire  [1:0] m_tuser;
    wire  m_tlast;

    particle_pool_update #(.POOL_DEPTH(DEPTH)) DUT (
        .clk(clk), .rst_n(rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tuser(m_tuser), .m_tlast(m_tlast)
    );

    always #1 clk = ~clk;

    // predictor state: the pool as the block should hold it
    logic signed [31:0] pool_pos [0:3*DEPTH-1];
    logic signed [31:0] pool_vel [0:3*DEPTH-1];
    logic [31:0] pool_size [0:DEPTH-1];
    logic signed [31:0] pool_life [0:DEPTH-1];
    logic signed [31:0] pool_total [0:DEPTH-1];
    logic signed [31:0] pool_grav [0:DEPTH-1];
    logic [31:0] pool_c0 [0:DEPTH-1];
    logic [31:0] pool_c1 [0:DEPTH-1];
    int unsigned live = 0;
    logic signed [31:0] gravity_reg = 0;
    int unsigned limit_reg = 64;

    item_t   pending_items[$];
    vertex_t expected_vertices[$];
    int  fail_count = 0;
    bit  idle_enable = 1'b1;
    bit  hold_request = 1'b0;
    int  hold_left = 0;
    int  send_gap = 0, recv_gap = 0;
    longint cycles = 0;

    function automatic logic signed [31:0] clamp32(longint v);
        if (v > 64'sd2147483647) return 32'h7fffffff;
        if (v < -64'sd2147483648) return 32'h80000000;
        return v[31:0];
    endfunction

    // q16.16 product, floor shift
    function automatic longint qmul(logic signed [31:0] a, longint dt);
        longint p;
        p = longint'(a) * dt;
        return p >>> 16;
    endfunction

    function automatic logic [31:0] mix_colour(logic [31:0] s, logic [31:0] e, longint t);
        logic [31:0] r;
        longint c;
        r = '0;
        for (int sh = 0; sh < 32; sh += 8) begin
            c = (longint'(s[sh +: 8]) * (65536 - t) + longint'(e[sh +: 8]) * t + 32768) >>> 16;
            if (c > 255) c = 255;
            r[sh +: 8] = c[7:0];
        end
        return r;
    endfunction

    function automatic vertex_t blank_vertex();
        vertex_t v;
        v = '{kind: ppu_pkg::KIND_SPAWN, accepted: 1'b0, x: '0, y: '0, z: '0, size: '0,
              rgba: '0, alive: '0, last: 1'b1};
        return v;
    endfunction

    // work out the results of one accepted item and advance the pool
    task automatic predict_pool(item_t it);
        vertex_t v;
        int unsigned cap, w;
        longint dt, life, frac, t;
        v = blank_vertex();
        if (it.op == ppu_pkg::OP_SPAWN) begin
            cap = (limit_reg > DEPTH) ? DEPTH : limit_reg;
            v.accepted = (live < cap);
            if (v.accepted) begin
                for (int j = 0; j < 3; j++) begin
                    pool_pos[3*live+j] = it.data[32*j +: 32];
                    pool_vel[3*live+j] = it.data[96+32*j +: 32];
                end
                pool_size[live]  = it.data[192 +: 32];
                pool_life[live]  = {1'b0, it.data[224 +: 31]};
                pool_total[live] = {1'b0, it.data[224 +: 31]};
                pool_grav[live]  = gravity_reg;
                pool_c0[live]    = it.data[255 +: 32];
                pool_c1[live]    = it.data[287 +: 32];
                live++;
            end
            v.alive = live[6:0];
            expected_vertices.push_back(v);
            return;
        end
        dt = longint'(it.data[319 +: 31]);
        w = 0;
        for (int unsigned i = 0; i < live; i++) begin
            life = longint'(pool_life[i]) - dt;
            if (life <= 0) continue;
            pool_life[w]  = life[31:0];
            pool_total[w] = pool_total[i];
            pool_grav[w]  = pool_grav[i];
            pool_size[w]  = pool_size[i];
            pool_c0[w]    = pool_c0[i];
            pool_c1[w]    = pool_c1[i];
            pool_vel[3*w]   = pool_vel[3*i];
            pool_vel[3*w+1] = clamp32(longint'(pool_vel[3*i+1]) + qmul(pool_grav[i], dt));
            pool_vel[3*w+2] = pool_vel[3*i+2];
            for (int j = 0; j < 3; j++)
                pool_pos[3*w+j] = clamp32(longint'(pool_pos[3*i+j]) + qmul(pool_vel[3*w+j], dt));
            w++;
        end
        live = w;
        if (live == 0) begin
            v.kind = ppu_pkg::KIND_EMPTY;
            expected_vertices.push_back(v);
            return;
        end
        for (int unsigned i = 0; i < live; i++) begin
            if (pool_total[i] <= 0) t = 65536;
            else begin
                frac = (longint'(pool_life[i]) <<< 16) / longint'(pool_total[i]);
                t = (frac >= 65536) ? 0 : 65536 - frac;
            end
            v = blank_vertex();
            v.kind  = ppu_pkg::KIND_RECORD;
            v.x = pool_pos[3*i]; v.y = pool_pos[3*i+1]; v.z = pool_pos[3*i+2];
            v.size  = pool_size[i];
            v.rgba  = mix_colour(pool_c0[i], pool_c1[i], t);
            v.alive = live[6:0];
            v.last  = (i + 1 == live);
            expected_vertices.push_back(v);
        end
    endtask

    // driver: offers queued items, random gaps between them
    always @(posedge clk)
    begin
        if (rst_n) begin
            if (s_tvalid && s_tready) predict_pool('{op: s_tuser, data: s_tdata});
            if (!s_tvalid || s_tready) begin
                if (send_gap > 0) begin
                    send_gap <= send_gap - 1;
                    s_tvalid <= 1'b0;
                end else if (pending_items.size() > 0) begin
                    item_t nx;
                    nx = pending_items.pop_front();
                    s_tvalid <= 1'b1;
                    s_tuser  <= nx.op;
                    s_tdata  <= nx.data;
                    if (idle_enable && $urandom_range(0, 5) == 0)
                        send_gap <= $urandom_range(1, 6);
                end else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // monitor: compares each result transfer with the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n) begin
            if (m_tvalid && m_tready) begin
                if (expected_vertices.size() == 0) begin
                    $display("%0t: unexpected result kind=%0d", $time, m_tuser);
                    fail_count++;
                end else begin
                    vertex_t e;
                    vertex_t a;
                    e = expected_vertices.pop_front();
                    a.kind = m_tuser;      a.accepted = m_tdata[0];
                    a.x = m_tdata[1 +: 32]; a.y = m_tdata[33 +: 32];
                    a.z = m_tdata[65 +: 32]; a.size = m_tdata[97 +: 32];
                    a.rgba = m_tdata[129 +: 32]; a.alive = m_tdata[161 +: 7];
                    a.last = m_tlast;
                    if (a !== e) begin
                        $display("%0t: mismatch expected kind=%0d acc=%0d x=%h y=%h z=%h size=%h rgba=%h alive=%0d last=%0d",
                                 $time, e.kind, e.accepted, e.x, e.y, e.z, e.size, e.rgba, e.alive, e.last);
                        $display("%0t:          actual   kind=%0d acc=%0d x=%h y=%h z=%h size=%h rgba=%h alive=%0d last=%0d",
                                 $time, a.kind, a.accepted, a.x, a.y, a.z, a.size, a.rgba, a.alive, a.last);
                        fail_count++;
                    end
                end
            end
        end
    end

    // receiver readiness: long hold when asked, else random stall bursts
    always @(posedge clk)
    begin
        if (rst_n) begin
            if (hold_request && hold_left == 0) begin
                hold_left <= 600;
                hold_request <= 1'b0;
                m_tready <= 1'b0;
            end else if (hold_left > 0) begin
                hold_left <= hold_left - 1;
                m_tready <= (hold_left == 1);
            end else if (recv_gap > 0) begin
                recv_gap <= recv_gap - 1;
                m_tready <= 1'b0;
            end else if (idle_enable && $urandom_range(0, 5) == 0) begin
                recv_gap <= $urandom_range(0, 5);
                m_tready <= 1'b0;
            end else
                m_tready <= 1'b1;
        end
    end

    // cycle cap
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_CAP) begin
            $display("FAIL");
            $finish;
        end
    end

    task automatic apb_write(logic [2:0] addr, logic [31:0] value);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= addr; pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        if (addr == ADDR_GRAVITY) gravity_reg = value;
        else limit_reg = value[6:0];
    endtask

    function automatic item_t spawn_item(logic [31:0] px, logic [31:0] py, logic [31:0] pz,
                                         logic [31:0] vx, logic [31:0] vy, logic [31:0] vz,
                                         logic [31:0] sz, logic [30:0] lt,
                                         logic [31:0] c0, logic [31:0] c1);
        item_t it;
        it.op = ppu_pkg::OP_SPAWN;
        it.data = {2'b00, 31'($urandom), c1, c0, lt, sz, vz, vy, vx, pz, py, px};
        return it;
    endfunction

    function automatic item_t tick_item(logic [30:0] dt);
        item_t it;
        it.op = ppu_pkg::OP_TICK;
        it.data = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                   $urandom, $urandom, $urandom, $urandom, $urandom};
        it.data[319 +: 31] = dt;
        it.data[351:350] = 2'b00;
        return it;
    endfunction

    // random spawn: modest motion mostly, full-range values sometimes
    function automatic item_t random_spawn();
        logic [31:0] f [0:6];
        logic [30:0] lt;
        for (int k = 0; k < 7; k++)
            f[k] = ($urandom_range(0, 7) == 0) ? $urandom : 32'($signed($urandom_range(0, 2000000)) - 1000000);
        case ($urandom_range(0, 5))
            0: lt = 31'($urandom);
            1: lt = 31'($urandom_range(0, 4));
            default: lt = 31'($urandom_range(65536, 655360));
        endcase
        return spawn_item(f[0], f[1], f[2], f[3], f[4], f[5], $urandom, lt, $urandom, $urandom);
    endfunction

    function automatic item_t random_tick();
        logic [30:0] dt;
        case ($urandom_range(0, 7))
            0: dt = 31'($urandom);
            1: dt = 31'd0;
            default: dt = 31'($urandom_range(256, 40000));
        endcase
        return tick_item(dt);
    endfunction

    // wait until every queued item is taken and every result has come back
    task automatic drain_all();
        while (pending_items.size() > 0 || s_tvalid || expected_vertices.size() > 0)
            @(posedge clk);
        repeat (TAIL_WAIT) @(posedge clk);
    endtask

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: field extremes, refused spawn, zero life, empty ticks, saturation
        apb_write(ADDR_GRAVITY, 32'h7fffffff);
        apb_write(ADDR_LIMIT, 32'd3);
        pending_items.push_back(tick_item(31'd100));
        pending_items.push_back(spawn_item(32'h7fffffff, 32'h80000000, 32'h0, 32'h7fffffff,
                                           32'h7fffffff, 32'h80000000, 32'hffffffff,
                                           31'h7fffffff, 32'hffffffff, 32'h0));
        pending_items.push_back(spawn_item(32'h80000000, 32'h7fffffff, 32'hffffffff,
                                           32'h80000000, 32'h80000000, 32'h7fffffff, 32'h0,
                                           31'd0, 32'h0, 32'hffffffff));
        pending_items.push_back(spawn_item(32'h0, 32'h0, 32'h0, 32'h10000, 32'h0, 32'h0,
                                           32'h10000, 31'd1, 32'h12345678, 32'h87654321));
        pending_items.push_back(spawn_item(32'h1, 32'h1, 32'h1, 32'h1, 32'h1, 32'h1,
                                           32'h1, 31'h10000, 32'h1, 32'h1));
        pending_items.push_back(tick_item(31'h7fffffff >> 8));
        pending_items.push_back(tick_item(31'd0));
        pending_items.push_back(tick_item(31'h7fffffff));
        pending_items.push_back(tick_item(31'd0));
        drain_all();

        apb_write(ADDR_GRAVITY, 32'h80000000);
        apb_write(ADDR_LIMIT, 32'd0);
        pending_items.push_back(random_spawn());
        drain_all();
        apb_write(ADDR_LIMIT, 32'd127);
        for (int k = 0; k < 4; k++) pending_items.push_back(random_spawn());
        pending_items.push_back(tick_item(31'd1));
        pending_items.push_back(tick_item(31'd65536));
        drain_all();

        // random phases through several settings; the long receiver hold in the first
        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: begin apb_write(ADDR_GRAVITY, 32'hfff60000); apb_write(ADDR_LIMIT, 32'd64); end
                1: begin apb_write(ADDR_GRAVITY, 32'h0);        apb_write(ADDR_LIMIT, 32'd1); end
                2: begin apb_write(ADDR_GRAVITY, $urandom);     apb_write(ADDR_LIMIT, 32'd100); end
                3: begin apb_write(ADDR_GRAVITY, 32'h00050000); apb_write(ADDR_LIMIT, 32'd8); end
                4: begin apb_write(ADDR_GRAVITY, 32'h7fffffff); apb_write(ADDR_LIMIT, 32'd64); end
                default: begin apb_write(ADDR_GRAVITY, 32'hffff0000); apb_write(ADDR_LIMIT, 32'd20); end
            endcase
            if (ph == 0) hold_request = 1'b1;
            if (ph == 5) idle_enable = 1'b0;
            for (int k = 0; k < 60; k++)
                pending_items.push_back(($urandom_range(0, 3) == 0) ? random_tick() : random_spawn());
            // a run of ticks to age the pool out
            for (int k = 0; k < 4; k++) pending_items.push_back(random_tick());
            drain_all();
        end

        if (fail_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end
endmodule
`default_nettype wire
